@@ rtl/core/brcp_pkg.sv @@
// ----------------------------------------------------------------------------
// brcp_pkg: shared types and constants of the balance robot cascade PID
// Fixed-point formats, loop limits, field and MAC widths and the register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brcp_pkg;

   // fixed point
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int ANGLE_FRAC_BITS = 8;

   // loop limits
   localparam int SPEED_MAX       = 4;
   localparam int TURN_MAX        = 250;
   localparam int INTEG_MAX       = 10000;
   localparam int OVERDRIVE_LEVEL = 6000;
   localparam int OVERDRIVE_TICKS = 20;
   localparam int MOTOR_MAX       = 7200;

   // field widths
   localparam int COUNT_W   = 16;
   localparam int ANGLE_W   = 17;
   localparam int RATE_W    = 16;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 13;
   localparam int MOTOR_W   = 14;
   localparam int SPEED_W   = 4;
   localparam int TURN_W    = 10;
   localparam int ERR_W     = 18;
   localparam int FE_W      = 18;
   localparam int INTEG_W   = 15;
   localparam int ODCNT_W   = 5;
   localparam int DIFF_W    = 18;
   localparam int FSUM_W    = 20;
   localparam int FMAG_W    = 19;

   // shared multiply-accumulate unit
   localparam int MUL_A_W = 21;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 50;
   localparam int SUM_W   = ACC_W + 1;

   // x / 5 = (x * RECIP_FIVE) >> RECIP_SHIFT, exact for x below 2^21 / 3
   localparam int RECIP_FIVE  = 419431;
   localparam int RECIP_SHIFT = 21;

   // register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BALANCE_ANGLE = 3'd0,
      CSR_BALANCE_KP    = 3'd1,
      CSR_BALANCE_KD    = 3'd2,
      CSR_SPEED_KP      = 3'd3,
      CSR_SPEED_KI      = 3'd4,
      CSR_STEER_KP      = 3'd5,
      CSR_DRIVE_LIMIT   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic en;      // update accumulator
      logic load;    // start from base instead of accumulator
      logic sub;     // subtract product
      logic shift;   // product scaled by the angle fraction
   } mac_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/brcp_mac.sv @@
// ----------------------------------------------------------------------------
// brcp_mac: shared signed multiply-accumulate unit
// One product per cycle, added to or subtracted from the accumulator or a base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brcp_mac (
   input  logic                                 clock,
   input  brcp_pkg::mac_ctrl_type               ctrl,
   input  logic signed [brcp_pkg::ACC_W-1:0]    base,
   input  logic signed [brcp_pkg::MUL_A_W-1:0]  op_a,
   input  logic signed [brcp_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [brcp_pkg::ACC_W-1:0]    acc
);
   import brcp_pkg::*;

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  start;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod = op_a * op_b;

   always_comb begin
      term = prod[ACC_W-1:0];
      if (ctrl.shift) begin
         term = term <<< ANGLE_FRAC_BITS;
      end
      start  = ctrl.load ? base : acc_ff;
      acc_in = acc_ff;
      if (ctrl.en) begin
         acc_in = ctrl.sub ? (start - term) : (start + term);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ rtl/core/balance_robot_cascade_pid_top.sv @@
// ----------------------------------------------------------------------------
// balance_robot_cascade_pid_top: cascaded balance / velocity / steering control
// One item at a time: req_stall is high from acceptance until the result is
// loaded, while the sequencer steps the one shared multiply-accumulate unit
// through seven products and four rescales.
// Reset (synchronous): registers and loop state to defaults, no item held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module balance_robot_cascade_pid_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [brcp_pkg::COUNT_W-1:0]    req_wheel_count_left,
   input  logic signed [brcp_pkg::COUNT_W-1:0]    req_wheel_count_right,
   input  logic signed [brcp_pkg::ANGLE_W-1:0]    req_pitch_angle,
   input  logic signed [brcp_pkg::RATE_W-1:0]     req_pitch_rate,
   input  logic signed [brcp_pkg::RATE_W-1:0]     req_yaw_rate,
   input  logic                                   req_btn_forward,
   input  logic                                   req_btn_backward,
   input  logic                                   req_btn_left,
   input  logic                                   req_btn_right,
   input  logic                                   req_clear_integral,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [brcp_pkg::MOTOR_W-1:0]    rsp_motor_left,
   output logic signed [brcp_pkg::MOTOR_W-1:0]    rsp_motor_right,
   output logic                                   rsp_overdrive_fault,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [brcp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [brcp_pkg::CSR_DATA_W-1:0]        csr_data
);
   import brcp_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'b0000_0000_0000_0001,
      ST_FSUM  = 16'b0000_0000_0000_0010,
      ST_FMUL  = 16'b0000_0000_0000_0100,
      ST_FUPD  = 16'b0000_0000_0000_1000,
      ST_INTEG = 16'b0000_0000_0001_0000,
      ST_V1    = 16'b0000_0000_0010_0000,
      ST_V2    = 16'b0000_0000_0100_0000,
      ST_VTR   = 16'b0000_0000_1000_0000,
      ST_B1    = 16'b0000_0001_0000_0000,
      ST_B2    = 16'b0000_0010_0000_0000,
      ST_BTR   = 16'b0000_0100_0000_0000,
      ST_P1    = 16'b0000_1000_0000_0000,
      ST_PTR   = 16'b0001_0000_0000_0000,
      ST_T1    = 16'b0010_0000_0000_0000,
      ST_TTR   = 16'b0100_0000_0000_0000,
      ST_OUT   = 16'b1000_0000_0000_0000
   } state_type;

   // divide by 2^k, rounding toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shift(
      input logic signed [ACC_W-1:0] x,
      input int unsigned             k
   );
      logic signed [ACC_W-1:0] bias;
      bias = '0;
      if (x[ACC_W-1]) begin
         bias = (ACC_W'(1) << k) - ACC_W'(1);
      end
      trunc_shift = (x + bias) >>> k;
   endfunction

   state_type state_ff, state_in;

   // configuration
   logic signed [ANGLE_W-1:0] balance_angle_ff;
   logic signed [GAIN_W-1:0]  balance_kp_ff, balance_kd_ff;
   logic signed [GAIN_W-1:0]  speed_kp_ff, speed_ki_ff, steer_kp_ff;
   logic [LIMIT_W-1:0]        drive_limit_ff;

   // loop state
   logic signed [SPEED_W-1:0] speed_target_ff, speed_target_in;
   logic signed [TURN_W-1:0]  turn_target_ff, turn_target_in;
   logic signed [FE_W-1:0]    filt_err_ff, filt_err_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic [ODCNT_W-1:0]        od_count_ff, od_count_in;

   // per-item working registers
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [RATE_W-1:0]  prate_ff, prate_in;
   logic signed [RATE_W-1:0]  yrate_ff, yrate_in;
   logic                      steady_ff, steady_in;
   logic                      clr_ff, clr_in;
   logic signed [FSUM_W-1:0]  fsum_ff, fsum_in;
   logic signed [MUL_B_W-1:0] vel_ff, vel_in;
   logic signed [MUL_B_W-1:0] vert_ff, vert_in;
   logic signed [MUL_B_W-1:0] turn_ff, turn_in;
   logic signed [ACC_W-1:0]   pwm_ff, pwm_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [MOTOR_W-1:0] motor_left_ff, motor_left_in;
   logic signed [MOTOR_W-1:0] motor_right_ff, motor_right_in;
   logic                      fault_ff, fault_in;

   // MAC interface
   mac_ctrl_type              mac_ctrl;
   logic signed [ACC_W-1:0]   mac_base;
   logic signed [MUL_A_W-1:0] mac_a;
   logic signed [MUL_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0]   mac_acc;

   // combinational helpers
   logic                      accept;
   logic                      out_free;
   logic signed [SPEED_W:0]   st_tmp;
   logic signed [TURN_W:0]    tt_tmp;
   logic signed [FSUM_W-1:0]  fsum_abs;
   logic signed [FE_W-1:0]    fe_mag;
   logic signed [INTEG_W+4-1:0] integ_sum;
   logic signed [SUM_W-1:0]   lim_s, sum_l, sum_r, clip_l, clip_r;
   logic [LIMIT_W-1:0]        lim;
   logic [ODCNT_W-1:0]        od_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   brcp_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .base  (mac_base),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   // sequencer and MAC operand selection
   always_comb begin
      state_in = state_ff;
      mac_ctrl = '0;
      mac_base = '0;
      mac_a    = '0;
      mac_b    = '0;
      fsum_abs = fsum_ff[FSUM_W-1] ? -fsum_ff : fsum_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_FSUM;
         end
         ST_FSUM: state_in = ST_FMUL;
         ST_FMUL: begin
            mac_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, shift: 1'b0};
            mac_a    = MUL_A_W'(RECIP_FIVE);
            mac_b    = MUL_B_W'(fsum_abs[FMAG_W-1:0]);
            state_in = ST_FUPD;
         end
         ST_FUPD:  state_in = ST_INTEG;
         ST_INTEG: state_in = ST_V1;
         ST_V1: begin
            mac_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, shift: 1'b0};
            mac_a    = MUL_A_W'(speed_kp_ff);
            mac_b    = MUL_B_W'(filt_err_ff);
            state_in = ST_V2;
         end
         ST_V2: begin
            mac_ctrl = '{en: 1'b1, load: 1'b0, sub: 1'b0, shift: 1'b0};
            mac_a    = MUL_A_W'(speed_ki_ff);
            mac_b    = MUL_B_W'(integ_ff);
            state_in = ST_VTR;
         end
         ST_VTR: state_in = ST_B1;
         ST_B1: begin
            mac_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, shift: 1'b0};
            mac_a    = MUL_A_W'(balance_kp_ff);
            mac_b    = MUL_B_W'(diff_ff);
            state_in = ST_B2;
         end
         ST_B2: begin
            mac_ctrl = '{en: 1'b1, load: 1'b0, sub: 1'b0, shift: 1'b1};
            mac_a    = MUL_A_W'(balance_kd_ff);
            mac_b    = MUL_B_W'(prate_ff);
            state_in = ST_BTR;
         end
         ST_BTR: state_in = ST_P1;
         ST_P1: begin
            mac_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b1, shift: 1'b0};
            mac_base = ACC_W'(vert_ff) <<< GAIN_FRAC_BITS;
            mac_a    = MUL_A_W'(balance_kp_ff);
            mac_b    = vel_ff;
            state_in = ST_PTR;
         end
         ST_PTR: state_in = ST_T1;
         ST_T1: begin
            // yaw damping only while no turn button is held
            mac_ctrl = '{en: 1'b1, load: 1'b1, sub: 1'b0, shift: 1'b0};
            mac_base = steady_ff ? (-(ACC_W'(yrate_ff)) <<< GAIN_FRAC_BITS) : '0;
            mac_a    = MUL_A_W'(steer_kp_ff);
            mac_b    = MUL_B_W'(turn_target_ff);
            state_in = ST_TTR;
         end
         ST_TTR: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      speed_target_in = speed_target_ff;
      turn_target_in  = turn_target_ff;
      filt_err_in     = filt_err_ff;
      integ_in        = integ_ff;
      od_count_in     = od_count_ff;
      err_in          = err_ff;
      diff_in         = diff_ff;
      prate_in        = prate_ff;
      yrate_in        = yrate_ff;
      steady_in       = steady_ff;
      clr_in          = clr_ff;
      fsum_in         = fsum_ff;
      vel_in          = vel_ff;
      vert_in         = vert_ff;
      turn_in         = turn_ff;
      pwm_in          = pwm_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      motor_left_in   = motor_left_ff;
      motor_right_in  = motor_right_ff;
      fault_in        = fault_ff;

      // targets ramp while held, drop to zero when released
      st_tmp = (!req_btn_forward && !req_btn_backward) ? '0 : (SPEED_W + 1)'(speed_target_ff);
      if (req_btn_forward)  st_tmp = st_tmp - (SPEED_W + 1)'(1);
      if (req_btn_backward) st_tmp = st_tmp + (SPEED_W + 1)'(1);
      tt_tmp = (!req_btn_left && !req_btn_right) ? '0 : (TURN_W + 1)'(turn_target_ff);
      if (req_btn_left)  tt_tmp = tt_tmp + (TURN_W + 1)'(1);
      if (req_btn_right) tt_tmp = tt_tmp - (TURN_W + 1)'(1);

      fe_mag    = FE_W'(mac_acc[RECIP_SHIFT +: FE_W]);
      integ_sum = (INTEG_W + 4)'(integ_ff) + (INTEG_W + 4)'(filt_err_ff);

      lim    = (drive_limit_ff > LIMIT_W'(MOTOR_MAX)) ? LIMIT_W'(MOTOR_MAX) : drive_limit_ff;
      lim_s  = SUM_W'(lim);
      sum_l  = SUM_W'(pwm_ff) - SUM_W'(turn_ff);
      sum_r  = SUM_W'(pwm_ff) + SUM_W'(turn_ff);
      clip_l = sum_l;
      if (sum_l > lim_s)       clip_l = lim_s;
      else if (sum_l < -lim_s) clip_l = -lim_s;
      clip_r = sum_r;
      if (sum_r > lim_s)       clip_r = lim_s;
      else if (sum_r < -lim_s) clip_r = -lim_s;
      od_next = od_count_ff + ODCNT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (st_tmp > SPEED_MAX)       speed_target_in = SPEED_W'(SPEED_MAX);
               else if (st_tmp < -SPEED_MAX) speed_target_in = SPEED_W'(-SPEED_MAX);
               else                          speed_target_in = st_tmp[SPEED_W-1:0];
               if (tt_tmp > TURN_MAX)        turn_target_in = TURN_W'(TURN_MAX);
               else if (tt_tmp < -TURN_MAX)  turn_target_in = TURN_W'(-TURN_MAX);
               else                          turn_target_in = tt_tmp[TURN_W-1:0];
               err_in = ERR_W'(req_wheel_count_left) + ERR_W'(req_wheel_count_right)
                        - ERR_W'(speed_target_in);
               diff_in   = DIFF_W'(req_pitch_angle) - DIFF_W'(balance_angle_ff);
               prate_in  = req_pitch_rate;
               yrate_in  = req_yaw_rate;
               steady_in = !req_btn_left && !req_btn_right;
               clr_in    = req_clear_integral;
            end
         end
         ST_FSUM: begin
            fsum_in = (FSUM_W'(err_ff) <<< 1) + FSUM_W'(filt_err_ff)
                      + (FSUM_W'(filt_err_ff) <<< 1);
         end
         ST_FUPD: begin
            filt_err_in = fsum_ff[FSUM_W-1] ? -fe_mag : fe_mag;
         end
         ST_INTEG: begin
            if (clr_ff)                  integ_in = '0;
            else if (integ_sum > INTEG_MAX)  integ_in = INTEG_W'(INTEG_MAX);
            else if (integ_sum < -INTEG_MAX) integ_in = INTEG_W'(-INTEG_MAX);
            else                         integ_in = integ_sum[INTEG_W-1:0];
         end
         ST_VTR: vel_in  = MUL_B_W'(trunc_shift(mac_acc, GAIN_FRAC_BITS));
         ST_BTR: vert_in = MUL_B_W'(trunc_shift(mac_acc, GAIN_FRAC_BITS + ANGLE_FRAC_BITS));
         ST_PTR: pwm_in  = trunc_shift(mac_acc, GAIN_FRAC_BITS);
         ST_TTR: turn_in = MUL_B_W'(trunc_shift(mac_acc, GAIN_FRAC_BITS));
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               motor_left_in  = clip_l[MOTOR_W-1:0];
               motor_right_in = clip_r[MOTOR_W-1:0];
               fault_in       = 1'b0;
               if (pwm_ff > OVERDRIVE_LEVEL || pwm_ff < -OVERDRIVE_LEVEL) begin
                  od_count_in = od_next;
                  if (od_next > ODCNT_W'(OVERDRIVE_TICKS)) begin
                     od_count_in = '0;
                     fault_in    = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         speed_target_ff <= SPEED_W'(3);
         turn_target_ff  <= TURN_W'(120);
         filt_err_ff     <= '0;
         integ_ff        <= '0;
         od_count_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         speed_target_ff <= speed_target_in;
         turn_target_ff  <= turn_target_in;
         filt_err_ff     <= filt_err_in;
         integ_ff        <= integ_in;
         od_count_ff     <= od_count_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         balance_angle_ff <= ANGLE_W'(-819);
         balance_kp_ff    <= '0;
         balance_kd_ff    <= '0;
         speed_kp_ff      <= '0;
         speed_ki_ff      <= '0;
         steer_kp_ff      <= '0;
         drive_limit_ff   <= LIMIT_W'(7000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BALANCE_ANGLE: balance_angle_ff <= csr_data[ANGLE_W-1:0];
            CSR_BALANCE_KP:    balance_kp_ff    <= csr_data[GAIN_W-1:0];
            CSR_BALANCE_KD:    balance_kd_ff    <= csr_data[GAIN_W-1:0];
            CSR_SPEED_KP:      speed_kp_ff      <= csr_data[GAIN_W-1:0];
            CSR_SPEED_KI:      speed_ki_ff      <= csr_data[GAIN_W-1:0];
            CSR_STEER_KP:      steer_kp_ff      <= csr_data[GAIN_W-1:0];
            CSR_DRIVE_LIMIT:   drive_limit_ff   <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff         <= err_in;
      diff_ff        <= diff_in;
      prate_ff       <= prate_in;
      yrate_ff       <= yrate_in;
      steady_ff      <= steady_in;
      clr_ff         <= clr_in;
      fsum_ff        <= fsum_in;
      vel_ff         <= vel_in;
      vert_ff        <= vert_in;
      turn_ff        <= turn_in;
      pwm_ff         <= pwm_in;
      motor_left_ff  <= motor_left_in;
      motor_right_ff <= motor_right_in;
      fault_ff       <= fault_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_left      = motor_left_ff;
   assign rsp_motor_right     = motor_right_ff;
   assign rsp_overdrive_fault = fault_ff;

`ifndef SYNTHESIS
   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      integ_ff <= INTEG_MAX && integ_ff >= -INTEG_MAX)
      else $error("velocity integral outside its clamp");

   a_od_range: assert property (@(posedge clock) disable iff (reset)
      od_count_ff <= ODCNT_W'(OVERDRIVE_TICKS))
      else $error("overdrive count passed its limit");

   a_targets: assert property (@(posedge clock) disable iff (reset)
      speed_target_ff <= SPEED_MAX && speed_target_ff >= -SPEED_MAX
      && turn_target_ff <= TURN_MAX && turn_target_ff >= -TURN_MAX)
      else $error("remote target outside its clamp");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not presented");
`endif

endmodule

`default_nettype wire

@@ bench/tb_balance_robot_cascade_pid_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balance_robot_cascade_pid_top: self-checking bench for the cascade PID
// Drives control ticks through the valid/stall input channel and predicts each
// motor item with a cycle-free model of the balance, velocity and steering
// loops. Settings are changed over the register port between phases of
// directed and random ticks, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_balance_robot_cascade_pid_top;
   import brcp_pkg::*;

   localparam int ANGLE_SPAN   = 46080;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_TICKS  = 170;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 3'd7;

   typedef struct {
      logic signed [COUNT_W-1:0] count_l;
      logic signed [COUNT_W-1:0] count_r;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [RATE_W-1:0]  pitch_rate;
      logic signed [RATE_W-1:0]  yaw_rate;
      logic                      fwd;
      logic                      back;
      logic                      left;
      logic                      right;
      logic                      clr;
   } tick_item_type;

   typedef struct {
      logic signed [MOTOR_W-1:0] motor_l;
      logic signed [MOTOR_W-1:0] motor_r;
      logic                      fault;
   } drive_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COUNT_W-1:0] req_wheel_count_left = '0;
   logic signed [COUNT_W-1:0] req_wheel_count_right = '0;
   logic signed [ANGLE_W-1:0] req_pitch_angle = '0;
   logic signed [RATE_W-1:0]  req_pitch_rate = '0;
   logic signed [RATE_W-1:0]  req_yaw_rate = '0;
   logic                      req_btn_forward = 1'b0;
   logic                      req_btn_backward = 1'b0;
   logic                      req_btn_left = 1'b0;
   logic                      req_btn_right = 1'b0;
   logic                      req_clear_integral = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [MOTOR_W-1:0] rsp_motor_left;
   logic signed [MOTOR_W-1:0] rsp_motor_right;
   logic                      rsp_overdrive_fault;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   balance_robot_cascade_pid_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   tick_item_type    tick_queue[$];
   drive_result_type expected_drives[$];
   tick_item_type    sent_tick;
   drive_result_type want;
   int            gap_left = 0;
   int            stall_left = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   bit            sender_jitter = 1'b1;
   bit            receiver_jitter = 1'b1;
   bit            calm = 1'b0;
   int            hold_left = 0;
   logic [3:0]    hold_btns = '0;

   // mirrored controller state and settings
   longint speed_tgt = 3, turn_tgt = 120, err_filt = 0, err_integ = 0;
   longint overdrive_ticks = 0;
   longint zero_angle = -819, bal_kp = 0, bal_kd = 0, spd_kp = 0, spd_ki = 0;
   longint steer_gain = 0, limit_cfg = 7000;

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic drive_result_type predict_drive(input tick_item_type t);
      longint gain_one, angle_one, err, vel, vert, pwm, damp, turn, lim, ml, mr;
      drive_result_type r;
      gain_one  = longint'(1) << GAIN_FRAC_BITS;
      angle_one = longint'(1) << ANGLE_FRAC_BITS;
      if (!t.fwd && !t.back) speed_tgt = 0;
      if (t.fwd) speed_tgt -= 1;
      if (t.back) speed_tgt += 1;
      speed_tgt = clip(speed_tgt, -SPEED_MAX, SPEED_MAX);
      if (!t.left && !t.right) turn_tgt = 0;
      if (t.left) turn_tgt += 1;
      if (t.right) turn_tgt -= 1;
      turn_tgt = clip(turn_tgt, -TURN_MAX, TURN_MAX);
      damp = (!t.left && !t.right) ? -1 : 0;

      err = longint'(t.count_l) + longint'(t.count_r) - speed_tgt;
      err_filt = (2 * err + 3 * err_filt) / 5;
      err_integ = clip(err_integ + err_filt, -INTEG_MAX, INTEG_MAX);
      if (t.clr) err_integ = 0;
      vel = (spd_kp * err_filt + spd_ki * err_integ) / gain_one;

      vert = (bal_kp * (longint'(t.pitch) - zero_angle)
              + bal_kd * longint'(t.pitch_rate) * angle_one) / (gain_one * angle_one);
      pwm  = (vert * gain_one - bal_kp * vel) / gain_one;
      turn = (damp * longint'(t.yaw_rate) * gain_one + steer_gain * turn_tgt) / gain_one;

      lim = limit_cfg > MOTOR_MAX ? MOTOR_MAX : limit_cfg;
      ml = clip(pwm - turn, -lim, lim);
      mr = clip(pwm + turn, -lim, lim);

      r.fault = 1'b0;
      if (pwm > OVERDRIVE_LEVEL || pwm < -OVERDRIVE_LEVEL) begin
         overdrive_ticks += 1;
         if (overdrive_ticks > OVERDRIVE_TICKS) begin
            overdrive_ticks = 0;
            r.fault = 1'b1;
         end
      end
      r.motor_l = ml[MOTOR_W-1:0];
      r.motor_r = mr[MOTOR_W-1:0];
      return r;
   endfunction

   // mostly short pauses, now and then a long one
   function automatic int pick_pause();
      case ($urandom_range(0, 19))
         0:       return $urandom_range(20, 80);
         1, 2:    return $urandom_range(4, 19);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic int pick_gap();
      if (!sender_jitter || $urandom_range(0, 1) == 0) return 0;
      return pick_pause();
   endfunction

   function automatic logic signed [COUNT_W-1:0] pick_word(input int mag);
      int s;
      case (calm ? 3 : $urandom_range(0, 9))
         0:             s = $urandom_range(0, 1) ? 32767 : -32768;
         1, 2, 3, 4, 5: s = int'($urandom_range(0, 2 * mag)) - mag;
         default:       s = $urandom;
      endcase
      return s[COUNT_W-1:0];
   endfunction

   function automatic logic signed [ANGLE_W-1:0] pick_angle(input int mag);
      int s;
      case (calm ? 3 : $urandom_range(0, 9))
         0:             s = $urandom_range(0, 1) ? ANGLE_SPAN : -ANGLE_SPAN;
         1, 2, 3, 4, 5: s = int'($urandom_range(0, 2 * mag)) - mag;
         default:       s = int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
      endcase
      return s[ANGLE_W-1:0];
   endfunction

   // upper data bits beyond the register width are random on purpose
   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      logic [CSR_DATA_W-1:0] v;
      int s;
      v = CSR_DATA_W'($urandom);
      s = int'($urandom_range(0, 1200)) - 600;
      case ($urandom_range(0, 9))
         0:          v[GAIN_W-1:0] = 16'h7fff;
         1:          v[GAIN_W-1:0] = 16'h8000;
         2, 3, 4, 5: v[GAIN_W-1:0] = s[GAIN_W-1:0];
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'($urandom);
      case ($urandom_range(0, 5))
         0:       v[LIMIT_W-1:0] = '0;
         1:       v[LIMIT_W-1:0] = LIMIT_W'(MOTOR_MAX);
         2:       v[LIMIT_W-1:0] = '1;
         default: v[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 8191));
      endcase
      return v;
   endfunction

   function automatic tick_item_type make_tick(input int cl, input int cr, input int pitch,
                                               input int prate, input int yaw,
                                               input logic [3:0] btns, input logic clr);
      tick_item_type t;
      t.count_l    = cl[COUNT_W-1:0];
      t.count_r    = cr[COUNT_W-1:0];
      t.pitch      = pitch[ANGLE_W-1:0];
      t.pitch_rate = prate[RATE_W-1:0];
      t.yaw_rate   = yaw[RATE_W-1:0];
      {t.fwd, t.back, t.left, t.right} = btns;
      t.clr        = clr;
      return t;
   endfunction

   function automatic tick_item_type random_tick(input logic [3:0] btns);
      tick_item_type t;
      t.count_l    = pick_word(calm ? 12 : 400);
      t.count_r    = pick_word(calm ? 12 : 400);
      t.pitch      = pick_angle(calm ? 600 : 8000);
      t.pitch_rate = pick_word(calm ? 300 : 4000);
      t.yaw_rate   = pick_word(calm ? 300 : 4000);
      {t.fwd, t.back, t.left, t.right} = btns;
      t.clr        = ($urandom_range(0, 11) == 0);
      return t;
   endfunction

   // buttons are held in runs so the targets ramp; a stray item breaks a run now and then
   task automatic queue_ticks(input int n);
      logic [3:0] stray;
      repeat (n) begin
         if (hold_left == 0) begin
            hold_btns = 4'($urandom);
            if ($urandom_range(0, 4) == 0) begin
               // one turn button alone, held for a long run that can reach the turn clamp
               hold_btns[1:0] = $urandom_range(0, 1) ? 2'b10 : 2'b01;
               hold_left = $urandom_range(180, 300);
            end else
               hold_left = $urandom_range(1, 24);
         end
         hold_left--;
         stray = 4'($urandom);
         if ($urandom_range(0, 19) == 0)
            tick_queue.push_back(random_tick(stray));
         else
            tick_queue.push_back(random_tick(hold_btns));
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BALANCE_ANGLE: zero_angle = longint'($signed(value[ANGLE_W-1:0]));
         CSR_BALANCE_KP:    bal_kp     = longint'($signed(value[GAIN_W-1:0]));
         CSR_BALANCE_KD:    bal_kd     = longint'($signed(value[GAIN_W-1:0]));
         CSR_SPEED_KP:      spd_kp     = longint'($signed(value[GAIN_W-1:0]));
         CSR_SPEED_KI:      spd_ki     = longint'($signed(value[GAIN_W-1:0]));
         CSR_STEER_KP:      steer_gain = longint'($signed(value[GAIN_W-1:0]));
         CSR_DRIVE_LIMIT:   limit_cfg  = longint'(value[LIMIT_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [CSR_DATA_W-1:0] angle, input logic [CSR_DATA_W-1:0] bkp,
                          input logic [CSR_DATA_W-1:0] bkd, input logic [CSR_DATA_W-1:0] skp,
                          input logic [CSR_DATA_W-1:0] ski, input logic [CSR_DATA_W-1:0] tkp,
                          input logic [CSR_DATA_W-1:0] lim);
      write_csr(CSR_BALANCE_ANGLE, angle);
      write_csr(CSR_BALANCE_KP, bkp);
      write_csr(CSR_BALANCE_KD, bkd);
      write_csr(CSR_SPEED_KP, skp);
      write_csr(CSR_SPEED_KI, ski);
      write_csr(CSR_STEER_KP, tkp);
      write_csr(CSR_DRIVE_LIMIT, lim);
   endtask

   // sampled on the falling edge so every update of the rising edge has settled
   task automatic wait_idle();
      @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_drives.size() != 0)
         @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_drives.push_back(predict_drive(sent_tick));
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (tick_queue.size() != 0) begin
               sent_tick = tick_queue.pop_front();
               req_wheel_count_left  <= sent_tick.count_l;
               req_wheel_count_right <= sent_tick.count_r;
               req_pitch_angle       <= sent_tick.pitch;
               req_pitch_rate        <= sent_tick.pitch_rate;
               req_yaw_rate          <= sent_tick.yaw_rate;
               req_btn_forward       <= sent_tick.fwd;
               req_btn_backward      <= sent_tick.back;
               req_btn_left          <= sent_tick.left;
               req_btn_right         <= sent_tick.right;
               req_clear_integral    <= sent_tick.clr;
               req_valid             <= 1'b1;
               gap_left              <= pick_gap();
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // monitor and result-side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_drives.size() == 0) begin
               $error("unexpected item: motor_left %0d motor_right %0d overdrive_fault %0b",
                      rsp_motor_left, rsp_motor_right, rsp_overdrive_fault);
               mismatch_count++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_motor_left !== want.motor_l) begin
                  $error("motor_left: expected %0d, got %0d", want.motor_l, rsp_motor_left);
                  mismatch_count++;
               end
               if (rsp_motor_right !== want.motor_r) begin
                  $error("motor_right: expected %0d, got %0d", want.motor_r, rsp_motor_right);
                  mismatch_count++;
               end
               if (rsp_overdrive_fault !== want.fault) begin
                  $error("overdrive_fault: expected %0b, got %0b", want.fault,
                         rsp_overdrive_fault);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (receiver_jitter && $urandom_range(0, 3) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_pause();
         end else
            rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings; first tick holds both buttons of each pair on the reset targets
      tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 4'b1111, 1'b0));
      tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 4'b1010, 1'b0));
      tick_queue.push_back(make_tick(0, 0, 0, 0, 32767, 4'b0000, 1'b0));
      tick_queue.push_back(make_tick(0, 0, 0, 0, -32768, 4'b0000, 1'b0));
      tick_queue.push_back(make_tick(32767, 32767, ANGLE_SPAN, 32767, 1000, 4'b0100, 1'b0));
      tick_queue.push_back(make_tick(-32768, -32768, -ANGLE_SPAN, -32768, -1000, 4'b1000,
                                     1'b1));
      tick_queue.push_back(make_tick(5, -3, 200, 10, -7, 4'b0010, 1'b0));
      tick_queue.push_back(make_tick(-5, 3, -200, -10, 7, 4'b0001, 1'b1));
      tick_queue.push_back(make_tick(100, 100, 1000, -500, 250, 4'b0000, 1'b0));
      wait_idle();

      // extreme gains, clamp above the motor maximum, and a write to an unused index
      set_all(CSR_DATA_W'(ANGLE_SPAN), 17'h07fff, 17'h08000, 17'h07fff, 17'h08000, 17'h07fff,
              17'h01fff);
      write_csr(CSR_IDX_UNUSED, '1);
      tick_queue.push_back(make_tick(0, 0, -ANGLE_SPAN, 32767, 0, 4'b0010, 1'b0));
      tick_queue.push_back(make_tick(0, 0, -ANGLE_SPAN, -32768, 0, 4'b0010, 1'b0));
      tick_queue.push_back(make_tick(32767, 32767, ANGLE_SPAN, 0, 32767, 4'b0001, 1'b0));
      tick_queue.push_back(make_tick(-32768, -32768, 0, 0, -32768, 4'b0000, 1'b1));
      tick_queue.push_back(make_tick(1, 1, 0, 0, 0, 4'b0110, 1'b0));
      tick_queue.push_back(make_tick(-1, -1, ANGLE_SPAN, -32768, 0, 4'b1001, 1'b0));
      tick_queue.push_back(make_tick(7, -7, 23040, 12345, -12345, 4'b1111, 1'b0));
      tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 4'b0000, 1'b1));
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         sender_jitter   = (p % 3 != 2);
         receiver_jitter = (p % 3 != 1);
         calm            = (p % 2 == 1);
         case (p)
            0: set_all(CSR_DATA_W'(-ANGLE_SPAN), 17'h07fff, 17'h07fff, 17'h07fff, 17'h07fff,
                       17'h07fff, CSR_DATA_W'(MOTOR_MAX));
            1: set_all(CSR_DATA_W'(ANGLE_SPAN), 17'h18000, 17'h18000, 17'h18000, 17'h18000,
                       17'h18000, '0);
            default: set_all(pick_angle(3000), pick_gain(), pick_gain(), pick_gain(),
                             pick_gain(), pick_gain(), pick_limit());
         endcase
         if ($urandom_range(0, 1) == 0) write_csr(CSR_IDX_UNUSED, CSR_DATA_W'($urandom));
         queue_ticks(PHASE_TICKS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ balance_robot_cascade_pid_top.f @@
rtl/core/brcp_pkg.sv
rtl/core/brcp_mac.sv
rtl/core/balance_robot_cascade_pid_top.sv
bench/tb_balance_robot_cascade_pid_top.sv
